FILE: rtl/core/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared widths, constants and the decision record of the UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ucd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int HOLD_N = 4;
  localparam int CNT_W  = 3;

  localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_TWO  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THR  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR = 21'h010000;

  localparam logic [BYTE_W-1:0] MASK_TWO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_TWO  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_THR  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_THR  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_FOUR = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_FOUR = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_CONT = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

  // One decision on the front of the hold queue
  typedef struct packed {
    logic             emit;
    logic             stop;
    logic [CNT_W-1:0] consume;
    logic [CP_W-1:0]  cp;
  } ucd_dec_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/ucd_in_if.sv
// ----------------------------------------------------------------------------
// ucd_in_if
// Byte channel into the UTF-8 decoder: valid/ready with byte and end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucd_in_if import ucd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ucd_out_if.sv
// ----------------------------------------------------------------------------
// ucd_out_if
// Code point channel out of the UTF-8 decoder: valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucd_out_if import ucd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            last_of_text;

  modport source (output valid, output code_point, output last_of_text, input ready);
  modport sink   (input valid, input code_point, input last_of_text, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ucd_judge.sv
// ----------------------------------------------------------------------------
// ucd_judge
// Shared form judge: classifies the lead at the queue front, checks the
// continuations, assembles the value and decides what to emit and consume.
// ----------------------------------------------------------------------------
`default_nettype none

module ucd_judge import ucd_pkg::*; (
  input  logic [HOLD_N-1:0][BYTE_W-1:0] hold_i,
  input  logic [CNT_W-1:0]              cnt_i,
  input  logic                          end_i,
  output ucd_dec_t                      dec_o
);

  logic [BYTE_W-1:0] lead;
  logic              c1, c2, c3;
  logic              multi;
  logic              ok;
  logic [CNT_W-1:0]  len;
  logic [CP_W-1:0]   val;
  logic [CP_W-1:0]   minimum;

  always_comb begin
    lead    = hold_i[0];
    c1      = (hold_i[1] & MASK_CONT) == CONT_TAG;
    c2      = (hold_i[2] & MASK_CONT) == CONT_TAG;
    c3      = (hold_i[3] & MASK_CONT) == CONT_TAG;
    multi   = 1'b1;
    ok      = 1'b0;
    len     = CNT_W'(1);
    val     = '0;
    minimum = '0;
    dec_o   = '{emit: 1'b1, stop: 1'b0, consume: CNT_W'(1), cp: REPL_CP};

    if (!lead[7]) begin
      multi    = 1'b0;
      dec_o.cp = {13'd0, lead};
    end else if ((lead & MASK_TWO) == LEAD_TWO) begin
      len     = CNT_W'(2);
      val     = {10'd0, lead[4:0], hold_i[1][5:0]};
      minimum = MIN_TWO;
      ok      = c1;
    end else if ((lead & MASK_THR) == LEAD_THR) begin
      len     = CNT_W'(3);
      val     = {5'd0, lead[3:0], hold_i[1][5:0], hold_i[2][5:0]};
      minimum = MIN_THR;
      ok      = c1 & c2;
    end else if ((lead & MASK_FOUR) == LEAD_FOUR) begin
      len     = CNT_W'(4);
      val     = {lead[2:0], hold_i[1][5:0], hold_i[2][5:0], hold_i[3][5:0]};
      minimum = MIN_FOUR;
      ok      = c1 & c2 & c3;
    end else begin
      multi = 1'b0;
    end

    if (multi) begin
      if (cnt_i < len) begin
        // truncated form: replace and drop the rest at end, else wait
        if (end_i) begin
          dec_o.consume = cnt_i;
        end else begin
          dec_o.emit = 1'b0;
          dec_o.stop = 1'b1;
          dec_o.consume = '0;
        end
      end else if (!ok || (val < minimum)) begin
        dec_o.consume = CNT_W'(1);
      end else begin
        dec_o.consume = len;
        if (!((val > MAX_CP) || ((val >= SURR_LO) && (val <= SURR_HI)))) begin
          dec_o.cp = val;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// Streaming UTF-8 to code point decoder with a four-byte hold queue.
// ----------------------------------------------------------------------------
//  channel  dir  payload                         beat
//  in_ch    in   byte_in[7:0], end_of_text       valid & ready
//  out_ch   out  code_point[20:0], last_of_text  valid & ready
//
//  Each byte is taken in the idle state; the run state then makes one
//  decision per step on the hold queue until the judge waits for more bytes
//  or the queue empties; a malformed form may yield several results.
//  The single form judge and the output register pace these decisions.
//  Synchronous active-low reset empties the queue and the output register.
//  A stalled output holds the sequencer unless the judge waits for bytes;
//  a new byte is taken while the last result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder import ucd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ucd_in_if.sink      in_ch,
  ucd_out_if.source   out_ch
);

  state_t                        state_r, state_nxt;
  logic [HOLD_N-1:0][BYTE_W-1:0] hold_r, hold_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          end_r, end_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]               out_cp_r, out_cp_nxt;
  logic                          out_last_r, out_last_nxt;

  ucd_dec_t dec;
  logic     in_fire;
  logic     out_free;
  logic     step_en;
  logic     emit_fire;

  ucd_judge u_judge (
    .hold_i (hold_r),
    .cnt_i  (cnt_r),
    .end_i  (end_r),
    .dec_o  (dec)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign step_en             = (state_r == S_RUN) && (dec.stop || out_free);
  assign emit_fire           = step_en && dec.emit;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = out_cp_r;
  assign out_ch.last_of_text = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    cnt_nxt       = cnt_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cp_nxt    = out_cp_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          hold_nxt[cnt_r[1:0]] = in_ch.byte_in;
          cnt_nxt              = cnt_r + CNT_W'(1);
          end_nxt              = in_ch.end_of_text;
          state_nxt            = S_RUN;
        end
      end
      S_RUN: begin
        if (step_en) begin
          if (dec.stop) begin
            state_nxt = S_IDLE;
          end else begin
            out_valid_nxt = 1'b1;
            out_cp_nxt    = dec.cp;
            out_last_nxt  = end_r && (cnt_r == dec.consume);
            cnt_nxt       = cnt_r - dec.consume;
            case (dec.consume)
              CNT_W'(1): hold_nxt = {8'h00, hold_r[3:1]};
              CNT_W'(2): hold_nxt = {16'h0000, hold_r[3:2]};
              CNT_W'(3): hold_nxt = {24'h000000, hold_r[3]};
              CNT_W'(4): hold_nxt = '0;
              default:   hold_nxt = hold_r;
            endcase
            if (cnt_r == dec.consume) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    out_cp_r   <= out_cp_nxt;
    out_last_r <= out_last_nxt;
  end

  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ((cnt_r != '0) && (cnt_r <= CNT_W'(HOLD_N))))
    else $error("hold count out of range while judging");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r < CNT_W'(HOLD_N)))
    else $error("hold queue full while idle");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && end_r && (cnt_r == dec.consume)) |=>
      ((cnt_r == '0) && (state_r == S_IDLE) && out_last_r))
    else $error("end of text left bytes in the queue");

endmodule

`default_nettype wire

FILE: sim/tb_utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Streams UTF-8 text into the decoder and checks every code point beat
// against a predicted queue. Directed forms cover the extremes, each form
// length and the malformed cases. A random part follows: mostly well-formed
// text, plus noise, broken, overlong, out-of-range and truncated forms.
// Both channels idle at random, and the receiver holds off once for a long
// stretch to fill the decoder.
// ----------------------------------------------------------------------------

import ucd_pkg::*;

typedef struct packed {
  logic [CP_W-1:0] cp;
  logic            last;
} cp_beat_t;

class code_point_ledger;
  logic [BYTE_W-1:0] held [HOLD_N];
  int                held_n;
  cp_beat_t          want_q [$];
  int                errors;

  function new();
    held_n = 0;
    errors = 0;
  endfunction

  // Predict the code points caused by one accepted byte
  function void take_byte(logic [BYTE_W-1:0] b, logic eot);
    logic [BYTE_W-1:0] win [HOLD_N];
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] c;
    logic [31:0]       val;
    logic [31:0]       floor_v;
    logic [CP_W-1:0]   cps [$];
    cp_beat_t          nb;
    int                n;
    int                pos;
    int                len;
    int                i;
    bit                good;
    for (i = 0; i < held_n; i++) win[i] = held[i];
    win[held_n] = b;
    n = held_n + 1;
    pos = 0;
    while (pos < n) begin
      lead = win[pos];
      if (lead < CONT_TAG) begin
        cps.insert(cps.size(), CP_W'(lead));
        pos++;
        continue;
      end
      if ((lead & MASK_TWO) == LEAD_TWO) begin
        val = 32'(lead & ~MASK_TWO); len = 2; floor_v = 32'(MIN_TWO);
      end else if ((lead & MASK_THR) == LEAD_THR) begin
        val = 32'(lead & ~MASK_THR); len = 3; floor_v = 32'(MIN_THR);
      end else if ((lead & MASK_FOUR) == LEAD_FOUR) begin
        val = 32'(lead & ~MASK_FOUR); len = 4; floor_v = 32'(MIN_FOUR);
      end else begin
        cps.insert(cps.size(), REPL_CP);
        pos++;
        continue;
      end
      if (n - pos < len) begin
        if (eot) begin
          cps.insert(cps.size(), REPL_CP);
          pos = n;
        end
        break;
      end
      good = 1'b1;
      for (i = 1; i < len; i++) begin
        c = win[pos + i];
        if ((c & MASK_CONT) != CONT_TAG) begin
          good = 1'b0;
          break;
        end
        val = (val << 6) | 32'(c & ~MASK_CONT);
      end
      if (!good || val < floor_v) begin
        cps.insert(cps.size(), REPL_CP);
        pos++;
        continue;
      end
      if (val > 32'(MAX_CP) || (val >= 32'(SURR_LO) && val <= 32'(SURR_HI)))
        val = 32'(REPL_CP);
      cps.insert(cps.size(), val[CP_W-1:0]);
      pos += len;
    end
    if (eot) begin
      held_n = 0;
    end else begin
      for (i = 0; i < n - pos; i++) held[i] = win[pos + i];
      held_n = n - pos;
    end
    for (i = 0; i < cps.size(); i++) begin
      nb.cp   = cps[i];
      nb.last = eot && (i == cps.size() - 1);
      want_q.insert(want_q.size(), nb);
    end
  endfunction

  function void match_point(logic [CP_W-1:0] cp, logic last);
    cp_beat_t w;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected beat, code point %h last %b", $time, cp, last);
      errors++;
      return;
    end
    w = want_q.pop_front();
    if (cp !== w.cp) begin
      $display("%0t: code point expected %h actual %h", $time, w.cp, cp);
      errors++;
    end
    if (last !== w.last) begin
      $display("%0t: last_of_text expected %b actual %b", $time, w.last, last);
      errors++;
    end
  endfunction
endclass

module tb_utf8_codepoint_decoder;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 258;
  localparam int DRAIN_WAIT  = 20;

  typedef enum int {
    F_WELL,
    F_NOISE,
    F_BADCONT,
    F_OVERLONG,
    F_RANGE,
    F_TRUNC
  } form_kind_t;

  logic clk;
  logic rst_n;

  ucd_in_if  in_ch ();
  ucd_out_if out_ch ();

  utf8_codepoint_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  code_point_ledger  ledger;
  logic [BYTE_W-1:0] text_q [$];
  int                bytes_sent;
  int                cycles;
  bit                send_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put_byte(logic [BYTE_W-1:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void push_form(logic [20:0] cp, int len);
    case (len)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_cp(int len);
    int unsigned r;
    case (len)
      1: r = $urandom_range(0, 'h7F);
      2: r = $urandom_range('h80, 'h7FF);
      3: begin
        r = $urandom_range('h800, 'hFFFF - 'h800);
        if (r >= 'hD800) r += 'h800;
      end
      default: r = $urandom_range('h10000, 'h10FFFF);
    endcase
    return r[20:0];
  endfunction

  function automatic form_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return F_WELL;
    if (r < 72) return F_NOISE;
    if (r < 81) return F_BADCONT;
    if (r < 88) return F_OVERLONG;
    if (r < 94) return F_RANGE;
    return F_TRUNC;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    int gap;
    gap = send_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.byte_in     <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ledger.take_byte(b, eot);
    bytes_sent++;
  endtask

  task automatic send_text(input logic eot);
    int i;
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], eot && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  // Receiver: random back-pressure, one long hold-off once the text is flowing
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    bit  calm;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    calm       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        ledger.match_point(out_ch.code_point, out_ch.last_of_text);
      if ($urandom_range(0, 199) == 0) calm = ~calm;
      if (!hold_done && bytes_sent >= 120) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    form_kind_t kind;
    int         len;
    int         drop;
    logic       eot;
    ledger            = new();
    bytes_sent        = 0;
    cycles            = 0;
    send_burst        = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.byte_in     <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each length, malformed forms
    text_q = '{8'h00};                    send_text(1'b1);
    text_q = '{8'hFF};                    send_text(1'b0);
    text_q = '{8'hC3, 8'hA9};             send_text(1'b0);
    text_q = '{8'hE2, 8'h82, 8'hAC};      send_text(1'b0);
    text_q = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_text(1'b0);
    text_q = '{8'hC3, 8'h41};             send_text(1'b0);
    text_q = '{8'hC0, 8'h80};             send_text(1'b0);
    text_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text(1'b0);
    text_q = '{8'hED, 8'hA0, 8'h80};      send_text(1'b1);
    text_q = '{8'hF0, 8'h41, 8'h42, 8'h43}; send_text(1'b0);
    text_q = '{8'hF0, 8'h9F};             send_text(1'b1);

    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
      kind = pick_kind();
      len  = $urandom_range(2, 4);
      eot  = ($urandom_range(0, 9) == 0);
      case (kind)
        F_WELL: begin
          len = $urandom_range(1, 4);
          push_form(pick_cp(len), len);
        end
        F_NOISE: begin
          repeat ($urandom_range(1, 3)) put_byte(BYTE_W'($urandom_range(0, 255)));
        end
        F_BADCONT: begin
          push_form(pick_cp(len), len);
          if ($urandom_range(0, 1)) begin
            text_q[$urandom_range(1, len - 1)] = BYTE_W'($urandom_range(0, 255));
          end else begin
            drop = $urandom_range(1, len - 1);
            repeat (drop) void'(text_q.pop_back());
          end
        end
        F_OVERLONG: begin
          case (len)
            2: push_form(21'($urandom_range(0, 'h7F)), 2);
            3: push_form(21'($urandom_range(0, 'h7FF)), 3);
            default: push_form(21'($urandom_range(0, 'hFFFF)), 4);
          endcase
        end
        F_RANGE: begin
          if ($urandom_range(0, 1)) push_form(21'($urandom_range('hD800, 'hDFFF)), 3);
          else push_form(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end
        default: begin
          push_form(pick_cp(len), len);
          drop = $urandom_range(1, len - 1);
          repeat (drop) void'(text_q.pop_back());
          eot = 1'b1;
        end
      endcase
      send_text(eot);
    end
    text_q = '{8'h0A};
    send_text(1'b1);
    in_ch.valid <= 1'b0;

    while (ledger.want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (ledger.want_q.size() != 0) begin
      $display("%0t: %0d code points never arrived", $time, ledger.want_q.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ucd_pkg.sv
rtl/core/ucd_in_if.sv
rtl/core/ucd_out_if.sv
rtl/core/ucd_judge.sv
rtl/core/utf8_codepoint_decoder.sv
sim/tb_utf8_codepoint_decoder.sv
